[rtl/core/ffa_pkg.sv]
// Shared constants, codes and control structs of the first-fit block allocator.
package ffa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int SIZE_BITS  = 32;

  localparam int OP_W     = 2;
  localparam int REQ_W    = 32;
  localparam int HANDLE_W = 6;
  localparam int LEN_W    = 32;
  localparam int PROD_W   = 2 * REQ_W;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W   = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
  localparam int REC_W   = SIZE_BITS + 1;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_ZALLOC  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOSPACE   = 2'd1,
    ST_ZERO      = 2'd2,
    ST_BADHANDLE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_HCHECK,
    S_GRAB,
    S_SCAN,
    S_APPEND,
    S_FREE_OLD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    load;
    logic    hread;
    logic    scan_start;
    logic    scan_step;
    logic    wr_mark_free;
    logic    wr_hit;
    logic    wr_append;
    logic    wr_free_old;
    logic    set_status;
    status_t status;
    logic    keep_handle;
    logic    save_old;
    logic    set_moved;
    logic    out_load;
  } ffa_cmd_t;

  typedef struct packed {
    op_t  op;
    logic present;
    logic in_range;
    logic rd_free;
    logic rd_fits_req;
    logic size_zero;
    logic size_too_big;
    logic table_full;
    logic scan_hit;
    logic scan_more;
    logic chk_pending;
    logic moving;
    logic out_busy;
  } ffa_sts_t;

endpackage

[rtl/core/ffa_in_if.sv]
// Request channel interface of the first-fit block allocator.
interface ffa_in_if;
  logic                           valid;
  logic                           ready;
  logic [ffa_pkg::OP_W-1:0]       operation;
  logic [ffa_pkg::REQ_W-1:0]      request_size;
  logic [ffa_pkg::REQ_W-1:0]      elem_size;
  logic [ffa_pkg::HANDLE_W-1:0]   handle;
  logic                           handle_present;

  modport source (
    output valid, operation, request_size, elem_size, handle, handle_present,
    input  ready
  );
  modport sink (
    input  valid, operation, request_size, elem_size, handle, handle_present,
    output ready
  );
endinterface

[rtl/core/ffa_out_if.sv]
// Result channel interface of the first-fit block allocator.
interface ffa_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     status;
  logic [ffa_pkg::HANDLE_W-1:0]   result_handle;
  logic                           moved;
  logic [ffa_pkg::LEN_W-1:0]      copy_length;
  logic [ffa_pkg::LEN_W-1:0]      zero_length;

  modport source (
    output valid, status, result_handle, moved, copy_length, zero_length,
    input  ready
  );
  modport sink (
    input  valid, status, result_handle, moved, copy_length, zero_length,
    output ready
  );
endinterface

[rtl/core/ffa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ffa_ctrl.sv]
// Controller state machine of the first-fit block allocator.
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ffa_pkg::ffa_sts_t sts,
  output ffa_pkg::ffa_cmd_t cmd
);

  ffa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.status = ffa_pkg::ST_OK;
    in_ready   = 1'b0;
    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ffa_pkg::S_DECODE;
        end
      end
      ffa_pkg::S_DECODE: begin
        unique case (sts.op)
          ffa_pkg::OP_ALLOC, ffa_pkg::OP_ZALLOC: begin
            state_nxt = ffa_pkg::S_GRAB;
          end
          ffa_pkg::OP_FREE, ffa_pkg::OP_REALLOC: begin
            if (!sts.present) begin
              state_nxt = (sts.op == ffa_pkg::OP_FREE) ? ffa_pkg::S_DONE : ffa_pkg::S_GRAB;
            end else if (!sts.in_range) begin
              cmd.set_status = 1'b1;
              cmd.status     = ffa_pkg::ST_BADHANDLE;
              state_nxt      = ffa_pkg::S_DONE;
            end else begin
              cmd.hread = 1'b1;
              state_nxt = ffa_pkg::S_HCHECK;
            end
          end
          default: begin
            state_nxt = ffa_pkg::S_DONE;
          end
        endcase
      end
      ffa_pkg::S_HCHECK: begin
        if (sts.rd_free) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffa_pkg::ST_BADHANDLE;
          state_nxt      = ffa_pkg::S_DONE;
        end else if (sts.op == ffa_pkg::OP_FREE) begin
          cmd.wr_mark_free = 1'b1;
          state_nxt        = ffa_pkg::S_DONE;
        end else if (sts.rd_fits_req) begin
          cmd.keep_handle = 1'b1;
          state_nxt       = ffa_pkg::S_DONE;
        end else begin
          cmd.save_old = 1'b1;
          state_nxt    = ffa_pkg::S_GRAB;
        end
      end
      ffa_pkg::S_GRAB: begin
        if (sts.size_zero) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffa_pkg::ST_ZERO;
          state_nxt      = ffa_pkg::S_DONE;
        end else if (sts.size_too_big) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffa_pkg::ST_NOSPACE;
          state_nxt      = ffa_pkg::S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = ffa_pkg::S_SCAN;
        end
      end
      ffa_pkg::S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.wr_hit = 1'b1;
          state_nxt  = sts.moving ? ffa_pkg::S_FREE_OLD : ffa_pkg::S_DONE;
        end else if (sts.scan_more || sts.chk_pending) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_nxt = ffa_pkg::S_APPEND;
        end
      end
      ffa_pkg::S_APPEND: begin
        if (sts.table_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ffa_pkg::ST_NOSPACE;
          state_nxt      = ffa_pkg::S_DONE;
        end else begin
          cmd.wr_append = 1'b1;
          state_nxt     = sts.moving ? ffa_pkg::S_FREE_OLD : ffa_pkg::S_DONE;
        end
      end
      ffa_pkg::S_FREE_OLD: begin
        cmd.wr_free_old = 1'b1;
        cmd.set_moved   = 1'b1;
        state_nxt       = ffa_pkg::S_DONE;
      end
      ffa_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/ffa_dp.sv]
// Datapath of the first-fit block allocator: request registers, record RAM, scan, result.
module ffa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ffa_pkg::ffa_cmd_t            cmd,
  output ffa_pkg::ffa_sts_t            sts,
  input  logic [ffa_pkg::OP_W-1:0]     in_operation,
  input  logic [ffa_pkg::REQ_W-1:0]    in_request_size,
  input  logic [ffa_pkg::REQ_W-1:0]    in_elem_size,
  input  logic [ffa_pkg::HANDLE_W-1:0] in_handle,
  input  logic                         in_handle_present,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [ffa_pkg::HANDLE_W-1:0] out_result_handle,
  output logic                         out_moved,
  output logic [ffa_pkg::LEN_W-1:0]    out_copy_length,
  output logic [ffa_pkg::LEN_W-1:0]    out_zero_length
);

  ffa_pkg::op_t                   op_r;
  logic [ffa_pkg::REQ_W-1:0]      req_r;
  logic [ffa_pkg::PROD_W-1:0]     prod_r;
  logic [ffa_pkg::HANDLE_W-1:0]   handle_r;
  logic                           present_r;
  logic [ffa_pkg::CNT_W-1:0]      count_r;
  logic [ffa_pkg::CNT_W-1:0]      idx_r;
  logic                           chk_v_r;
  logic [ffa_pkg::IDX_W-1:0]      chk_idx_r;
  logic [ffa_pkg::SIZE_BITS-1:0]  old_size_r;
  ffa_pkg::status_t               status_r;
  logic [ffa_pkg::IDX_W-1:0]      granted_r;
  logic                           moving_r;
  logic                           moved_r;
  logic                           out_valid_r;
  logic [1:0]                     out_status_r;
  logic [ffa_pkg::HANDLE_W-1:0]   out_handle_r;
  logic                           out_moved_r;
  logic [ffa_pkg::LEN_W-1:0]      out_copy_r;
  logic [ffa_pkg::LEN_W-1:0]      out_zero_r;

  logic [ffa_pkg::PROD_W-1:0]     size_w;
  logic [ffa_pkg::PROD_W-1:0]     rd_size_wide;
  logic [ffa_pkg::PROD_W-1:0]     old_size_wide;
  logic [ffa_pkg::IDX_W-1:0]      handle_idx;
  logic [ffa_pkg::IDX_W-1:0]      count_idx;
  logic [ffa_pkg::REC_W-1:0]      rdata;
  logic                           rd_free;
  logic [ffa_pkg::SIZE_BITS-1:0]  rd_size;
  logic                           ram_we;
  logic [ffa_pkg::IDX_W-1:0]      ram_waddr;
  logic [ffa_pkg::REC_W-1:0]      ram_wdata;
  logic                           ram_re;
  logic [ffa_pkg::IDX_W-1:0]      ram_raddr;
  logic                           ok;

  assign size_w        = (op_r == ffa_pkg::OP_ZALLOC) ? prod_r : ffa_pkg::PROD_W'(req_r);
  assign rd_free       = rdata[ffa_pkg::SIZE_BITS];
  assign rd_size       = rdata[ffa_pkg::SIZE_BITS-1:0];
  assign rd_size_wide  = ffa_pkg::PROD_W'(rd_size);
  assign old_size_wide = ffa_pkg::PROD_W'(old_size_r);
  assign handle_idx    = ffa_pkg::IDX_W'(handle_r);
  assign count_idx     = count_r[ffa_pkg::IDX_W-1:0];

  assign sts.op           = op_r;
  assign sts.present      = present_r;
  assign sts.in_range     = ffa_pkg::CMP_W'(handle_r) < ffa_pkg::CMP_W'(count_r);
  assign sts.rd_free      = rd_free;
  assign sts.rd_fits_req  = rd_size_wide >= ffa_pkg::PROD_W'(req_r);
  assign sts.size_zero    = (size_w == '0);
  assign sts.size_too_big = (size_w >> ffa_pkg::SIZE_BITS) != '0;
  assign sts.table_full   = (count_r == ffa_pkg::CNT_W'(ffa_pkg::MAX_BLOCKS));
  assign sts.scan_hit     = chk_v_r && rd_free && (rd_size_wide >= size_w);
  assign sts.scan_more    = (idx_r < count_r);
  assign sts.chk_pending  = chk_v_r;
  assign sts.moving       = moving_r;
  assign sts.out_busy     = out_valid_r && !out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = handle_idx;
    ram_wdata = {1'b1, rd_size};
    if (cmd.wr_mark_free) begin
      ram_we = 1'b1;
    end else if (cmd.wr_hit) begin
      ram_we    = 1'b1;
      ram_waddr = chk_idx_r;
      ram_wdata = {1'b0, rd_size};
    end else if (cmd.wr_append) begin
      ram_we    = 1'b1;
      ram_waddr = count_idx;
      ram_wdata = {1'b0, size_w[ffa_pkg::SIZE_BITS-1:0]};
    end else if (cmd.wr_free_old) begin
      ram_we    = 1'b1;
      ram_wdata = {1'b1, old_size_r};
    end
  end

  assign ram_re    = cmd.hread || (cmd.scan_step && sts.scan_more);
  assign ram_raddr = cmd.hread ? handle_idx : idx_r[ffa_pkg::IDX_W-1:0];

  ffa_ram #(
    .WIDTH (ffa_pkg::REC_W),
    .DEPTH (ffa_pkg::MAX_BLOCKS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= ffa_pkg::op_t'(in_operation);
      req_r     <= in_request_size;
      prod_r    <= ffa_pkg::PROD_W'(in_request_size) * ffa_pkg::PROD_W'(in_elem_size);
      handle_r  <= in_handle;
      present_r <= in_handle_present;
      status_r  <= ffa_pkg::ST_OK;
      granted_r <= '0;
      moving_r  <= 1'b0;
      moved_r   <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        status_r <= cmd.status;
      end
      if (cmd.keep_handle) begin
        granted_r <= handle_idx;
      end
      if (cmd.wr_hit) begin
        granted_r <= chk_idx_r;
      end
      if (cmd.wr_append) begin
        granted_r <= count_idx;
      end
      if (cmd.save_old) begin
        old_size_r <= rd_size;
        moving_r   <= 1'b1;
      end
      if (cmd.set_moved) begin
        moved_r <= 1'b1;
      end
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_step && sts.scan_more) begin
      idx_r     <= idx_r + 1'b1;
      chk_idx_r <= idx_r[ffa_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      chk_v_r <= 1'b0;
    end else begin
      if (cmd.wr_append) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.scan_start || cmd.wr_hit) begin
        chk_v_r <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_v_r <= sts.scan_more;
      end
    end
  end

  assign ok = (status_r == ffa_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_handle_r <= ok ? ffa_pkg::HANDLE_W'(granted_r) : '0;
      out_moved_r  <= ok && moved_r;
      out_copy_r   <= (ok && moved_r) ? old_size_wide[ffa_pkg::LEN_W-1:0] : '0;
      out_zero_r   <= (ok && op_r == ffa_pkg::OP_ZALLOC) ? size_w[ffa_pkg::LEN_W-1:0] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_handle = out_handle_r;
  assign out_moved         = out_moved_r;
  assign out_copy_length   = out_copy_r;
  assign out_zero_length   = out_zero_r;

endmodule

[rtl/core/first_fit_block_allocator_unit.sv]
// Top level of the first-fit block allocator.
// A null free or an out-of-range handle goes from decode straight to the result; other frees
// and a kept reallocate first read the record; a zero or oversized size stops in grab.
// A scan stops at the first fit; on a miss it runs over all records before the append. A reallocate
// with a handle reads its record first, and a move frees the old record last. One request at
// a time: the next is accepted the cycle after the result loads the output register.
// Reset (synchronous, active low) empties the table at once; no clearing pass.
module first_fit_block_allocator_unit (
  input logic       clk,
  input logic       rst_n,
  ffa_in_if.sink    in_chan,
  ffa_out_if.source out_chan
);

  ffa_pkg::ffa_cmd_t cmd;
  ffa_pkg::ffa_sts_t sts;
  logic              in_ready;

  assign in_chan.ready = in_ready;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_chan.operation),
    .in_request_size   (in_chan.request_size),
    .in_elem_size      (in_chan.elem_size),
    .in_handle         (in_chan.handle),
    .in_handle_present (in_chan.handle_present),
    .out_valid         (out_chan.valid),
    .out_ready         (out_chan.ready),
    .out_status        (out_chan.status),
    .out_result_handle (out_chan.result_handle),
    .out_moved         (out_chan.moved),
    .out_copy_length   (out_chan.copy_length),
    .out_zero_length   (out_chan.zero_length)
  );

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr_mark_free, cmd.wr_hit, cmd.wr_append, cmd.wr_free_old}))
    else $error("more than one record write in a cycle");

  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_append |-> !sts.table_full)
    else $error("append into a full table");

  a_hit_checked: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_hit |-> sts.chk_pending)
    else $error("grant without a checked record");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request taken while one is in flight");

endmodule

[tb/ffa_tb_pkg.sv]
// Request tracker for the first-fit allocator testbench: record table copy and expected grants.
package ffa_tb_pkg;
  import ffa_pkg::*;

  localparam logic [PROD_W-1:0] SIZE_LIMIT = PROD_W'({SIZE_BITS{1'b1}});

  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic                moved;
    logic [LEN_W-1:0]    copy_length;
    logic [LEN_W-1:0]    zero_length;
  } grant_t;

  class alloc_ledger;
    logic [SIZE_BITS-1:0] rec_size [MAX_BLOCKS];
    bit                   rec_free [MAX_BLOCKS];
    int                   rec_count;
    grant_t               pending_grants[$];
    int                   errors;

    function new();
      rec_count = 0;
      errors = 0;
    endfunction

    function bit is_live(logic [HANDLE_W-1:0] h);
      return (int'(h) < rec_count) && !rec_free[h];
    endfunction

    function int live_handle();
      int live[$];
      for (int i = 0; i < rec_count; i++) begin
        if (!rec_free[i]) live.push_back(i);
      end
      if (live.size() == 0) return -1;
      return live[$urandom_range(live.size() - 1)];
    endfunction

    function status_t first_fit(logic [PROD_W-1:0] size, output logic [HANDLE_W-1:0] idx);
      idx = '0;
      if (size == 0) return ST_ZERO;
      if (size > SIZE_LIMIT) return ST_NOSPACE;
      for (int i = 0; i < rec_count; i++) begin
        if (rec_free[i] && PROD_W'(rec_size[i]) >= size) begin
          rec_free[i] = 1'b0;
          idx = HANDLE_W'(i);
          return ST_OK;
        end
      end
      if (rec_count >= MAX_BLOCKS) return ST_NOSPACE;
      rec_size[rec_count] = size[SIZE_BITS-1:0];
      rec_free[rec_count] = 1'b0;
      idx = HANDLE_W'(rec_count);
      rec_count++;
      return ST_OK;
    endfunction

    function void note_request(op_t op, logic [REQ_W-1:0] req, logic [REQ_W-1:0] esz,
                               logic [HANDLE_W-1:0] h, logic present);
      grant_t              g;
      logic [PROD_W-1:0]   prod;
      logic [HANDLE_W-1:0] idx;
      g.status = ST_OK;
      g.handle = '0;
      g.moved = 1'b0;
      g.copy_length = '0;
      g.zero_length = '0;
      idx = '0;
      case (op)
        OP_ALLOC: begin
          g.status = first_fit(PROD_W'(req), idx);
        end
        OP_FREE: begin
          if (present) begin
            if (is_live(h)) rec_free[h] = 1'b1;
            else g.status = ST_BADHANDLE;
          end
        end
        OP_REALLOC: begin
          if (!present) begin
            g.status = first_fit(PROD_W'(req), idx);
          end else if (!is_live(h)) begin
            g.status = ST_BADHANDLE;
          end else if (rec_size[h] >= req) begin
            idx = h;
          end else begin
            g.status = first_fit(PROD_W'(req), idx);
            if (g.status == ST_OK) begin
              g.moved = 1'b1;
              g.copy_length = LEN_W'(rec_size[h]);
              rec_free[h] = 1'b1;
            end
          end
        end
        default: begin
          prod = PROD_W'(req) * PROD_W'(esz);
          if (prod > SIZE_LIMIT) begin
            g.status = ST_NOSPACE;
          end else begin
            g.status = first_fit(prod, idx);
            if (g.status == ST_OK) g.zero_length = prod[LEN_W-1:0];
          end
        end
      endcase
      if (g.status == ST_OK) g.handle = idx;
      else g.copy_length = '0;
      pending_grants.push_back(g);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_grant(logic [1:0] status, logic [HANDLE_W-1:0] handle, logic moved,
                              logic [LEN_W-1:0] copy_length, logic [LEN_W-1:0] zero_length);
      grant_t g;
      if (pending_grants.size() == 0) begin
        $error("result with no request pending: status %0d handle %0d", status, handle);
        errors++;
        return;
      end
      g = pending_grants.pop_front();
      cmp_field("status", 32'(g.status), 32'(status));
      cmp_field("result_handle", 32'(g.handle), 32'(handle));
      cmp_field("moved", 32'(g.moved), 32'(moved));
      cmp_field("copy_length", g.copy_length, copy_length);
      cmp_field("zero_length", g.zero_length, zero_length);
    endfunction
  endclass

endpackage

[tb/tb.sv]
// Top-level testbench of the first-fit block allocator unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;
  import ffa_tb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          in_quiet;
  bit          out_quiet;
  int          out_stall;
  alloc_ledger ledger;

  ffa_in_if  in_chan();
  ffa_out_if out_chan();

  first_fit_block_allocator_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(99) < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [REQ_W-1:0] rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 45) return $urandom_range(64, 1);
    if (r < 75) return $urandom_range(4096, 1);
    if (r < 95) return $urandom;
    return '1;
  endfunction

  task automatic send_request(op_t op, logic [REQ_W-1:0] req, logic [REQ_W-1:0] esz,
                              logic [HANDLE_W-1:0] h, logic present);
    int gap;
    gap = 0;
    if (!in_quiet && $urandom_range(99) < 30) gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.operation      <= op;
    in_chan.request_size   <= req;
    in_chan.elem_size      <= esz;
    in_chan.handle         <= h;
    in_chan.handle_present <= present;
    do @(posedge clk); while (!in_chan.ready);
    ledger.note_request(op, req, esz, h, present);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (ledger.pending_grants.size() != 0);
  endtask

  task automatic random_request();
    int                  pick;
    int                  r;
    int                  lh;
    logic [HANDLE_W-1:0] h;
    logic                present;
    logic [REQ_W-1:0]    req;
    logic [REQ_W-1:0]    esz;
    pick = $urandom_range(99);
    h = HANDLE_W'($urandom_range(63));
    present = 1'b1;
    if ($urandom_range(99) < 10) begin
      present = 1'b0;
    end else if ($urandom_range(99) < 85) begin
      lh = ledger.live_handle();
      if (lh >= 0) h = HANDLE_W'(lh);
    end
    if (pick < 35) begin
      send_request(OP_ALLOC, rand_size(), $urandom, h, present);
    end else if (pick < 60) begin
      send_request(OP_FREE, $urandom, $urandom, h, present);
    end else if (pick < 80) begin
      send_request(OP_REALLOC, rand_size(), $urandom, h, present);
    end else begin
      r = $urandom_range(99);
      if (r < 60) begin
        req = $urandom_range(64);
        esz = $urandom_range(64, 1);
      end else if (r < 80) begin
        req = $urandom_range(16);
        esz = $urandom_range(65535);
      end else begin
        req = $urandom;
        esz = $urandom;
      end
      send_request(OP_ZALLOC, req, esz, h, present);
    end
  endtask

  always @(posedge clk) begin
    if ($urandom_range(199) == 0) out_quiet <= ~out_quiet;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_stall > 0) begin
      out_chan.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (!out_quiet && $urandom_range(99) < 20) begin
      out_chan.ready <= 1'b0;
      out_stall <= pick_gap() - 1;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      ledger.check_grant(out_chan.status, out_chan.result_handle, out_chan.moved,
                         out_chan.copy_length, out_chan.zero_length);
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    ledger = new();
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.operation      <= OP_ALLOC;
    in_chan.request_size   <= '0;
    in_chan.elem_size      <= '0;
    in_chan.handle         <= '0;
    in_chan.handle_present <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_ALLOC,   32'd0,          32'd0,          6'd0,  1'b0);
    send_request(OP_FREE,    32'd0,          32'd0,          6'd0,  1'b0);
    send_request(OP_FREE,    32'd0,          32'd0,          6'd5,  1'b1);
    send_request(OP_REALLOC, 32'd0,          32'd0,          6'd0,  1'b0);
    send_request(OP_ALLOC,   32'd1,          32'd0,          6'd0,  1'b0);
    send_request(OP_ALLOC,   32'hFFFF_FFFF,  32'hFFFF_FFFF,  6'd63, 1'b1);
    send_request(OP_ZALLOC,  32'd0,          32'd5,          6'd0,  1'b0);
    send_request(OP_ZALLOC,  32'hFFFF_FFFF,  32'd2,          6'd0,  1'b0);
    send_request(OP_ZALLOC,  32'd65536,      32'd65535,      6'd0,  1'b0);
    send_request(OP_ZALLOC,  32'd3,          32'd0,          6'd0,  1'b0);
    send_request(OP_ZALLOC,  32'd1,          32'hFFFF_FFFF,  6'd0,  1'b0);
    send_request(OP_ZALLOC,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  6'd0,  1'b0);
    send_request(OP_REALLOC, 32'd0,          32'd0,          6'd0,  1'b1);
    send_request(OP_REALLOC, 32'd100,        32'd0,          6'd0,  1'b1);
    send_request(OP_FREE,    32'd0,          32'd0,          6'd0,  1'b1);
    send_request(OP_ALLOC,   32'd1,          32'd0,          6'd0,  1'b0);
    send_request(OP_FREE,    32'd0,          32'd0,          6'd1,  1'b1);
    send_request(OP_REALLOC, 32'd1000,       32'd0,          6'd4,  1'b1);
    send_request(OP_REALLOC, 32'd8,          32'd0,          6'd63, 1'b1);
    send_request(OP_FREE,    32'd0,          32'd0,          6'd2,  1'b1);
    send_request(OP_ALLOC,   32'd5,          32'd0,          6'd0,  1'b0);
    send_request(OP_REALLOC, 32'hFFFF_FFFF,  32'd0,          6'd0,  1'b1);
    drain();

    for (int n = 0; n < 1450; n++) begin
      if (n % 64 == 0) in_quiet = ($urandom_range(3) == 0);
      if (n % 250 == 249) drain();
      random_request();
    end

    drain();
    repeat (80) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending_grants.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
